// ----- hw/rtl/tcpq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_pkg: shared definitions of the two-class priority queue
// Holds the queue depth, derived widths, operation codes and the per-cell
// control word that the top level drives into the cell chain.
// ----------------------------------------------------------------------------
package tcpq_pkg;

  localparam int CAPACITY = 16;
  localparam int CntW     = $clog2(CAPACITY + 1);
  localparam int IdxW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IdW      = 16;
  localparam int KeyW     = 8;

  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_SERVE    = 2'd1;
  localparam logic [1:0] OP_WITHDRAW = 2'd2;
  localparam logic [1:0] OP_QUERY    = 2'd3;

  typedef enum logic [1:0] {
    MV_HOLD = 2'd0,
    MV_LOAD = 2'd1,
    MV_PREV = 2'd2,
    MV_NEXT = 2'd3
  } cell_mv_e;

  typedef struct packed {
    cell_mv_e mv;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/tcpq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_cell: one slot of the queue
// Stores an id and a key, compares its id with the request id, and takes
// new data from the request, its tail-side or its head-side neighbor.
// ----------------------------------------------------------------------------
module tcpq_cell import tcpq_pkg::*; (
  input  logic            clk_i,
  input  cell_ctrl_t      ctrl_i,
  input  logic            in_use_i,
  input  logic [IdW-1:0]  cmp_id_i,
  input  logic [KeyW-1:0] new_key_i,
  input  logic [IdW-1:0]  prev_id_i,
  input  logic [KeyW-1:0] prev_key_i,
  input  logic [IdW-1:0]  next_id_i,
  input  logic [KeyW-1:0] next_key_i,
  output logic [IdW-1:0]  id_o,
  output logic [KeyW-1:0] key_o,
  output logic            hit_o
);

  logic [IdW-1:0]  id_q, id_d;
  logic [KeyW-1:0] key_q, key_d;

  always_comb begin
    id_d  = id_q;
    key_d = key_q;
    unique case (ctrl_i.mv)
      MV_HOLD: begin
        id_d  = id_q;
        key_d = key_q;
      end
      MV_LOAD: begin
        id_d  = cmp_id_i;
        key_d = new_key_i;
      end
      MV_PREV: begin
        id_d  = prev_id_i;
        key_d = prev_key_i;
      end
      MV_NEXT: begin
        id_d  = next_id_i;
        key_d = next_key_i;
      end
      default: begin
        id_d  = id_q;
        key_d = key_q;
      end
    endcase
  end

  // Payload only: slots beyond the occupancy are never looked at.
  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    key_q <= key_d;
  end

  assign id_o  = id_q;
  assign key_o = key_q;
  assign hit_o = in_use_i && (id_q == cmp_id_i);

endmodule

// ----- hw/rtl/two_class_priority_queue_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_priority_queue_top: bounded two-class queue with cancel
// A chain of slot cells holds the preferred class at the head and the
// non-preferred class behind it; inserts, serves and withdrawals shift the
// chain by one slot.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                      Direction
//  -------   -------------------------------------------  ---------
//  request   in_valid_i, in_stall_o, op_i, entry_id_i,     in
//            entry_key_i
//  result    out_valid_o, out_stall_i, success_o,          out
//            served_id_o, found_key_o, occupancy_o
//  config    cfg_we_i, cfg_wdata_i (priority threshold)    in
//
// All cells compare their id with the request in parallel and the whole
// chain shifts at the same edge, so one beat per cycle is sustained while
// the result side does not stall. The result is loaded into the output
// register on acceptance. The request side stalls only while a result
// beat waits and the result side stalls it. Reset empties the queue
// at once (no clearing pass) and loads a threshold of 60.
//
module two_class_priority_queue_top import tcpq_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             op_i,
  input  logic [IdW-1:0]         entry_id_i,
  input  logic [KeyW-1:0]        entry_key_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   success_o,
  output logic [IdW-1:0]         served_id_o,
  output logic signed [KeyW:0]   found_key_o,
  output logic [CntW-1:0]        occupancy_o,
  input  logic                   cfg_we_i,
  input  logic [KeyW-1:0]        cfg_wdata_i
);

  // Cell chain signals.
  cell_ctrl_t      ctrl  [CAPACITY];
  logic [IdW-1:0]  ids   [CAPACITY];
  logic [KeyW-1:0] keys  [CAPACITY];
  logic [CAPACITY-1:0] hit;

  // Control state.
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] pcount_q, pcount_d;
  logic [KeyW-1:0] thr_q;

  // Result register.
  logic                 out_valid_q, out_valid_d;
  logic                 success_q, success_d;
  logic [IdW-1:0]       served_q, served_d;
  logic signed [KeyW:0] found_q, found_d;
  logic [CntW-1:0]      occ_q;

  logic            accept;
  logic            any_hit;
  logic [IdxW-1:0] hit_pos;
  logic [KeyW-1:0] hit_key;
  logic            pref;
  logic            ins_ok, srv_ok, wd_ok, rm_ok;
  logic [CntW-1:0] ins_at;
  logic [CntW-1:0] rm_pos;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Ids are unique, so at most one cell hits and an OR of the hit cells
  // yields its position and key.
  always_comb begin
    any_hit = 1'b0;
    hit_pos = '0;
    hit_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit[i]) begin
        any_hit = 1'b1;
        hit_pos = hit_pos | IdxW'(i);
        hit_key = hit_key | keys[i];
      end
    end
  end

  always_comb begin
    pref   = (entry_key_i >= thr_q);
    ins_ok = accept && (op_i == OP_INSERT) && !any_hit &&
             (count_q < CntW'(CAPACITY));
    srv_ok = accept && (op_i == OP_SERVE) && (count_q != '0);
    wd_ok  = accept && (op_i == OP_WITHDRAW) && any_hit;
    rm_ok  = srv_ok || wd_ok;
    ins_at = pref ? pcount_q : count_q;
    rm_pos = srv_ok ? '0 : CntW'(hit_pos);
  end

  // Per-cell moves: an insert opens a gap at its place by moving later
  // entries toward the tail; a removal closes the gap toward the head.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctrl[i].mv = MV_HOLD;
      if (ins_ok) begin
        if (CntW'(i) == ins_at) begin
          ctrl[i].mv = MV_LOAD;
        end else if (CntW'(i) > ins_at) begin
          ctrl[i].mv = MV_PREV;
        end
      end else if (rm_ok) begin
        if (CntW'(i) >= rm_pos) begin
          ctrl[i].mv = MV_NEXT;
        end
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [IdW-1:0]  prev_id, next_id;
    logic [KeyW-1:0] prev_key, next_key;

    if (g == 0) begin : g_head
      assign prev_id  = entry_id_i;
      assign prev_key = entry_key_i;
    end else begin : g_body
      assign prev_id  = ids[g-1];
      assign prev_key = keys[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign next_id  = ids[g];
      assign next_key = keys[g];
    end else begin : g_inner
      assign next_id  = ids[g+1];
      assign next_key = keys[g+1];
    end

    // A cell takes part in the id compare only while it is occupied.
    tcpq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl[g]),
      .in_use_i   (CntW'(g) < count_q),
      .cmp_id_i   (entry_id_i),
      .new_key_i  (entry_key_i),
      .prev_id_i  (prev_id),
      .prev_key_i (prev_key),
      .next_id_i  (next_id),
      .next_key_i (next_key),
      .id_o       (ids[g]),
      .key_o      (keys[g]),
      .hit_o      (hit[g])
    );
  end

  // Counters. A removal in front of the class boundary moves the boundary.
  always_comb begin
    count_d  = count_q;
    pcount_d = pcount_q;
    if (ins_ok) begin
      count_d = count_q + CntW'(1);
      if (pref) begin
        pcount_d = pcount_q + CntW'(1);
      end
    end else if (rm_ok) begin
      count_d = count_q - CntW'(1);
      if (rm_pos < pcount_q) begin
        pcount_d = pcount_q - CntW'(1);
      end
    end
  end

  always_comb begin
    success_d = ins_ok || rm_ok ||
                ((op_i == OP_QUERY) && any_hit);
    served_d  = srv_ok ? ids[0] : '0;
    found_d   = ((op_i == OP_QUERY) && any_hit) ? $signed({1'b0, hit_key}) : '1;
  end

  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pcount_q    <= '0;
      thr_q       <= KeyW'(60);
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      pcount_q    <= pcount_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  // Result payload is loaded on acceptance only, so it holds while stalled.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      success_q <= success_d;
      served_q  <= served_d;
      found_q   <= found_d;
      occ_q     <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign success_o   = success_q;
  assign served_id_o = served_q;
  assign found_key_o = found_q;
  assign occupancy_o = occ_q;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the two-class priority queue
// Sends insert, serve, withdraw and query requests with random gaps while
// the result side stalls on its own schedule. A local model of the slot
// chain predicts each result beat, and a monitor compares every result
// field by field. The threshold register is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import tcpq_pkg::*;

  // One expected result beat, with the same fields as the output ports.
  typedef struct {
    logic                 success;
    logic [IdW-1:0]       served_id;
    logic signed [KeyW:0] found_key;
    logic [CntW-1:0]      occupancy;
  } outcome_t;

  // Receiver stall schedules. Each one runs for a random stretch of cycles.
  typedef enum int {
    STALL_NONE   = 0,
    STALL_LIGHT  = 1,
    STALL_BLOCKS = 2,
    STALL_HEAVY  = 3
  } stall_mode_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [1:0]           op_i;
  logic [IdW-1:0]       entry_id_i;
  logic [KeyW-1:0]      entry_key_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 success_o;
  logic [IdW-1:0]       served_id_o;
  logic signed [KeyW:0] found_key_o;
  logic [CntW-1:0]      occupancy_o;
  logic                 cfg_we_i;
  logic [KeyW-1:0]      cfg_wdata_i;

  // Local copy of the queue contents. Slots below pref_count hold the
  // preferred class; slots from pref_count up to entry_count-1 hold the rest.
  logic [IdW-1:0]  slot_id   [CAPACITY];
  logic [KeyW-1:0] slot_key  [CAPACITY];
  int              entry_count;
  int              pref_count;
  logic [KeyW-1:0] threshold;

  outcome_t        expected_results[$];
  outcome_t        want;
  int              fail_count;

  // Sender burst control. With idles off, every request goes out back to back.
  int              burst_left;
  bit              sender_idles;
  logic [IdW-1:0]  id_pool[24];

  // Receiver stall schedule state.
  stall_mode_e     stall_mode;
  int              stall_mode_left;
  int              stall_run;
  bit              stall_level;

  two_class_priority_queue_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .entry_id_i  (entry_id_i),
    .entry_key_i (entry_key_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .success_o   (success_o),
    .served_id_o (served_id_o),
    .found_key_o (found_key_o),
    .occupancy_o (occupancy_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Removes the entry at pos and closes the gap toward the head. Removing a
  // preferred entry moves the class boundary down by one, wherever it sits.
  function automatic void drop_slot(int pos);
    for (int i = pos; i + 1 < entry_count; i++) begin
      slot_id[i]  = slot_id[i + 1];
      slot_key[i] = slot_key[i + 1];
    end
    if (pos < pref_count) pref_count--;
    entry_count--;
  endfunction

  // Applies one accepted request to the local queue and returns the result
  // beat that the block must produce for it.
  function automatic outcome_t apply_request(logic [1:0] op, logic [IdW-1:0] id,
                                             logic [KeyW-1:0] key);
    outcome_t res;
    int       pos;
    int       at;
    res.success   = 1'b0;
    res.served_id = '0;
    res.found_key = -9'sd1;
    pos = -1;
    for (int i = entry_count - 1; i >= 0; i--) begin
      if (slot_id[i] == id) pos = i;
    end
    case (op)
      OP_INSERT: begin
        // A duplicate id or a full queue rejects the insert and changes nothing.
        if (pos < 0 && entry_count < CAPACITY) begin
          at = (key >= threshold) ? pref_count : entry_count;
          for (int i = entry_count; i > at; i--) begin
            slot_id[i]  = slot_id[i - 1];
            slot_key[i] = slot_key[i - 1];
          end
          slot_id[at]  = id;
          slot_key[at] = key;
          entry_count++;
          if (key >= threshold) pref_count++;
          res.success = 1'b1;
        end
      end
      OP_SERVE: begin
        if (entry_count > 0) begin
          res.served_id = slot_id[0];
          drop_slot(0);
          res.success = 1'b1;
        end
      end
      OP_WITHDRAW: begin
        if (pos >= 0) begin
          drop_slot(pos);
          res.success = 1'b1;
        end
      end
      default: begin
        if (pos >= 0) begin
          res.found_key = $signed({1'b0, slot_key[pos]});
          res.success   = 1'b1;
        end
      end
    endcase
    res.occupancy = entry_count[CntW-1:0];
    return res;
  endfunction

  // Sends one request beat. The sender runs in bursts; at the start of each
  // burst it may drop valid for a random gap. The task starts and ends on a
  // falling edge, so valid is never lowered and raised in the same step.
  task automatic send_request(input logic [1:0] op, input logic [IdW-1:0] id,
                              input logic [KeyW-1:0] key);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (sender_idles && $urandom_range(0, 9) > 2) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    op_i        <= op;
    entry_id_i  <= id;
    entry_key_i <= key;
    // The beat is taken at the first rising edge where the block does not
    // stall. The stall is read before the block's registers update.
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(apply_request(op, id, key));
    @(negedge clk_i);
  endtask

  // Drops valid and waits until every predicted result has been seen, then
  // lets the result register settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // Register writes only happen with the block idle.
  task automatic write_threshold(input logic [KeyW-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    threshold = value;
  endtask

  // Random traffic. Most withdraws and queries name an id that is stored at
  // the moment, so the shifting paths get exercised; the rest use a small
  // pool of ids (to make duplicates likely) or a fully random id.
  task automatic run_random_phase(input int count, input int insert_pct);
    int          pick;
    int          key_val;
    logic [1:0]  op;
    logic [IdW-1:0] id;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < insert_pct) op = OP_INSERT;
      else if (pick < insert_pct + (100 - insert_pct) / 3) op = OP_SERVE;
      else if ($urandom_range(0, 1) == 0) op = OP_WITHDRAW;
      else op = OP_QUERY;
      pick = $urandom_range(0, 99);
      if (op != OP_INSERT && entry_count > 0 && pick < 55)
        id = slot_id[$urandom_range(0, entry_count - 1)];
      else if (pick < 88)
        id = id_pool[$urandom_range(0, 23)];
      else
        id = IdW'($urandom);
      // Keys near the threshold check the at-or-above comparison.
      if ($urandom_range(0, 4) == 0) begin
        key_val = int'(threshold) + int'($urandom_range(0, 2)) - 1;
        if (key_val < 0) key_val = 0;
        if (key_val > 255) key_val = 255;
      end else begin
        key_val = $urandom_range(0, 255);
      end
      send_request(op, id, key_val[KeyW-1:0]);
    end
  endtask

  // Covers the corner cases with the reset threshold of 60: serve and
  // withdraw on an empty queue, keys at the extremes and right at and below
  // the threshold, ids at the extremes, a full queue, a duplicate id, the
  // withdraw of a preferred entry that is not at the head, and queries of
  // present and absent ids.
  task automatic test_special_cases();
    logic [KeyW-1:0] key_by_lane[4];
    key_by_lane[0] = 8'd255;
    key_by_lane[1] = 8'd0;
    key_by_lane[2] = 8'd60;
    key_by_lane[3] = 8'd59;
    send_request(OP_SERVE, 16'h0000, 8'h00);
    send_request(OP_WITHDRAW, 16'h1234, 8'h00);
    // Fill all sixteen slots; ids run from 0000 to FFFF.
    for (int i = 0; i < CAPACITY; i++) begin
      send_request(OP_INSERT, IdW'(i) * 16'h1111, key_by_lane[i % 4]);
    end
    send_request(OP_INSERT, 16'h7777, 8'd200);
    send_request(OP_WITHDRAW, 16'h2222, 8'h00);
    send_request(OP_INSERT, 16'hFFFF, 8'd10);
    send_request(OP_QUERY, 16'hFFFF, 8'h00);
    send_request(OP_QUERY, 16'h1234, 8'h00);
    send_request(OP_SERVE, 16'hABCD, 8'hFF);
    send_request(OP_INSERT, 16'h5A5A, 8'd255);
    send_request(OP_SERVE, 16'h0000, 8'h00);
    drain_results();
  endtask

  // General mix at a random threshold between the extremes. Halfway through,
  // the sender holds off until every outstanding result has been returned.
  task automatic test_random_mix();
    write_threshold(KeyW'($urandom_range(1, 254)));
    run_random_phase(100, 40);
    drain_results();
    run_random_phase(100, 40);
  endtask

  // Threshold at both ends: with 0 every entry is preferred, with 255 only
  // a key of 255 is. The class of stored entries must not change on a write.
  task automatic test_threshold_extremes();
    write_threshold(8'd0);
    run_random_phase(150, 45);
    write_threshold(8'd255);
    run_random_phase(150, 45);
  endtask

  // Insert-heavy traffic keeps the queue at or near capacity.
  task automatic test_full_queue();
    write_threshold(8'd128);
    run_random_phase(200, 70);
  endtask

  // No sender gaps: one request per cycle whenever the result side allows.
  task automatic test_back_to_back();
    write_threshold(8'd60);
    sender_idles = 1'b0;
    run_random_phase(225, 50);
    sender_idles = 1'b1;
  endtask

  // Result side: the stall follows its own schedule, switching between no
  // stalls, light random stalls, long blocks and heavy stalling.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_mode_left == 0) begin
        stall_mode      = stall_mode_e'($urandom_range(0, 3));
        stall_mode_left = $urandom_range(32, 160);
      end
      stall_mode_left--;
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_BLOCKS: begin
          if (stall_run == 0) begin
            stall_run   = $urandom_range(1, 8);
            stall_level = ~stall_level;
          end
          stall_run--;
          out_stall_i <= stall_level;
        end
        default:     out_stall_i <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  task automatic check_field(input string name, input logic [IdW-1:0] exp_val,
                             input logic [IdW-1:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // Every result beat taken at a rising edge is matched with the oldest
  // prediction. The outputs are read before the block updates them.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: result beat with no request outstanding", $time);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("success", IdW'(want.success), IdW'(success_o));
        check_field("served_id", want.served_id, served_id_o);
        check_field("found_key", IdW'(want.found_key[KeyW:0]), IdW'(found_key_o[KeyW:0]));
        check_field("occupancy", IdW'(want.occupancy), IdW'(occupancy_o));
      end
    end
  end

  // Watchdog: stops a run that hangs and reports it as failed.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    op_i            = OP_INSERT;
    entry_id_i      = '0;
    entry_key_i     = '0;
    out_stall_i     = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    entry_count     = 0;
    pref_count      = 0;
    threshold       = 8'd60;
    fail_count      = 0;
    burst_left      = 0;
    sender_idles    = 1'b1;
    stall_mode      = STALL_NONE;
    stall_mode_left = 0;
    stall_run       = 0;
    stall_level     = 1'b0;
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < 24; i++) id_pool[i] = IdW'($urandom);

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_special_cases();
    test_random_mix();
    test_threshold_extremes();
    test_full_queue();
    test_back_to_back();

    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
